@@ src/hav_pkg.sv @@
// Shared constants and helper functions for the haversine distance unit.
package hav_pkg;

    localparam int LAT_W  = 28;
    localparam int LON_W  = 29;
    localparam int DIST_W = 31;
    localparam int DW     = 34;  // working width for angles in degree units
    localparam int AW     = 32;  // magnitude of an angle in degree units
    localparam int MW     = 57;  // degree-to-radian product
    localparam int CW     = 34;  // CORDIC datapath
    localparam int SW     = 62;  // square root datapath
    localparam int PW     = 45;  // angle times diameter
    localparam int SQRT_STEPS = 31;

    localparam logic [24:0]            DEG2RAD_Q30   = 25'd18740330;
    localparam logic signed [CW-1:0]   INV_GAIN      = 34'sd652032874;
    localparam logic [13:0]            TWO_RADIUS_KM = 14'd12742;
    localparam logic [DIST_W-1:0]      DIST_MAX      = 31'd1311769600;
    localparam logic [30:0]            Q30_ONE       = 31'h4000_0000;

    function automatic logic signed [CW-1:0] atan_q30(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'h3243F6A8;
            1:  v = 32'h1DAC6705;
            2:  v = 32'h0FADBAFC;
            3:  v = 32'h07F56EA6;
            4:  v = 32'h03FEAB76;
            5:  v = 32'h01FFD55B;
            6:  v = 32'h00FFFAAA;
            7:  v = 32'h007FFF55;
            8:  v = 32'h003FFFEA;
            9:  v = 32'h001FFFFD;
            10: v = 32'h000FFFFF;
            11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF;
            13: v = 32'h0001FFFF;
            14: v = 32'h0000FFFF;
            15: v = 32'h00007FFF;
            16: v = 32'h00003FFF;
            17: v = 32'h00001FFF;
            18: v = 32'h00000FFF;
            19: v = 32'h000007FF;
            20: v = 32'h000003FF;
            21: v = 32'h000001FF;
            22: v = 32'h000000FF;
            23: v = 32'h0000007F;
            24: v = 32'h0000003F;
            25: v = 32'h0000001F;
            26: v = 32'h0000000F;
            27: v = 32'h00000008;
            28: v = 32'h00000004;
            29: v = 32'h00000002;
            30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return CW'(v);
    endfunction

    // limit a CORDIC output to [0, 1] in Q30
    function automatic logic [30:0] clamp_unit(input logic signed [CW-1:0] v);
        logic [30:0] r;
        if (v < 0)
            r = '0;
        else if (v > $signed({3'b000, Q30_ONE}))
            r = Q30_ONE;
        else
            r = v[30:0];
        return r;
    endfunction

endpackage

@@ src/hav_if.sv @@
// Channel interfaces: point pair in, distance out.
interface hav_in_if;
    import hav_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [LAT_W-1:0]  first_latitude;
    logic signed [LON_W-1:0]  first_longitude;
    logic signed [LAT_W-1:0]  second_latitude;
    logic signed [LON_W-1:0]  second_longitude;

    modport source (output valid, first_latitude, first_longitude, second_latitude,
                    second_longitude, input ready);
    modport sink   (input valid, first_latitude, first_longitude, second_latitude,
                    second_longitude, output ready);
endinterface

interface hav_out_if;
    import hav_pkg::*;
    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance_km;

    modport source (output valid, distance_km, input ready);
    modport sink   (input valid, distance_km, output ready);
endinterface

@@ src/hav_rot_cell.sv @@
// One rotation-mode CORDIC iteration with its output register.
module hav_rot_cell
    import hav_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [CW-1:0] x_in,
    input  logic signed [CW-1:0] y_in,
    input  logic signed [CW-1:0] z_in,
    output logic signed [CW-1:0] x_reg,
    output logic signed [CW-1:0] y_reg,
    output logic signed [CW-1:0] z_reg
);

    localparam logic signed [CW-1:0] ATAN = atan_q30(STEP);

    logic signed [CW-1:0] dx, dy, x_next, y_next, z_next;

    always_comb
    begin
        dx = y_in >>> STEP;
        dy = x_in >>> STEP;
        if (z_in >= 0)
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ATAN;
        end
        else
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ATAN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

endmodule

@@ src/hav_vec_cell.sv @@
// One vectoring-mode CORDIC iteration with its output register.
module hav_vec_cell
    import hav_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [CW-1:0] x_in,
    input  logic signed [CW-1:0] y_in,
    input  logic signed [CW-1:0] z_in,
    output logic signed [CW-1:0] x_reg,
    output logic signed [CW-1:0] y_reg,
    output logic signed [CW-1:0] z_reg
);

    localparam logic signed [CW-1:0] ATAN = atan_q30(STEP);

    logic signed [CW-1:0] dx, dy, x_next, y_next, z_next;

    always_comb
    begin
        dx = y_in >>> STEP;
        dy = x_in >>> STEP;
        if (y_in > 0)
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ATAN;
        end
        else
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ATAN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

endmodule

@@ src/hav_sqrt_cell.sv @@
// One result bit of a restoring integer square root, registered.
module hav_sqrt_cell
    import hav_pkg::*;
#(
    parameter int POS = 0
)
(
    input  logic          clk,
    input  logic          en,
    input  logic [SW-1:0] v_in,
    input  logic [SW-1:0] r_in,
    output logic [SW-1:0] v_reg,
    output logic [SW-1:0] r_reg
);

    localparam logic [SW-1:0] BIT = SW'(1) << (2 * POS);

    logic [SW-1:0] trial, v_next, r_next;

    always_comb
    begin
        trial = r_in + BIT;
        if (v_in >= trial)
        begin
            v_next = v_in - trial;
            r_next = (r_in >> 1) + BIT;
        end
        else
        begin
            v_next = v_in;
            r_next = r_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg <= v_next;
            r_reg <= r_next;
        end
    end

endmodule

@@ src/haversine_distance_unit.sv @@
// Throughput: one point pair per cycle unless the output stalls; the whole row
// of cells advances together. A stalled output holds the row; ready drops only
// while the output item waits.
// Reset clears the valid bits of every stage; no clearing pass is needed.
// Stages: clamp, difference, fold, radians, rotation cells, products, sum,
// square root cells, vectoring cells, scale, round.
module haversine_distance_unit
    import hav_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 20,
    parameter int CORDIC_STEPS    = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    hav_in_if.sink      points,
    hav_out_if.source   result
);

    localparam int N      = CORDIC_STEPS;
    localparam int STAGES = 41 + 2 * N;

    localparam logic signed [DW-1:0] LAT_LIM   = DW'(64'd90 << ANGLE_FRAC_BITS);
    localparam logic signed [DW-1:0] LON_LIM   = DW'(64'd180 << ANGLE_FRAC_BITS);
    localparam logic [DW-1:0]        HALF_TURN = DW'(64'd180 << ANGLE_FRAC_BITS);
    localparam logic [DW-1:0]        FULL_TURN = DW'(64'd360 << ANGLE_FRAC_BITS);
    localparam logic [MW-1:0]        RND_HALF  = MW'(1) << ANGLE_FRAC_BITS;
    localparam logic [MW-1:0]        RND_FULL  = MW'(1) << (ANGLE_FRAC_BITS - 1);

    function automatic logic signed [DW-1:0] clamp_mag(input logic signed [DW-1:0] v,
                                                      input logic signed [DW-1:0] lim);
        logic signed [DW-1:0] r;
        if (v > lim)
            r = lim;
        else if (v < -lim)
            r = -lim;
        else
            r = v;
        return r;
    endfunction

    logic                adv;
    logic [STAGES-1:0]   vld_reg;

    assign adv          = !result.valid || result.ready;
    assign points.ready = adv;
    assign result.valid = vld_reg[STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[STAGES-2:0], points.valid};
    end

    // front end: clamp, differences, magnitudes, radians
    logic signed [DW-1:0] p1_lat1_reg, p1_lon1_reg, p1_lat2_reg, p1_lon2_reg;
    logic signed [DW-1:0] p2_dlat_reg, p2_dlon_reg, p2_lat1_reg, p2_lat2_reg;
    logic [AW-1:0]        p3_m_reg [4];
    logic [AW-1:0]        p3_m_next [4];
    logic [MW-1:0]        p4_prod_reg [4];
    logic signed [CW-1:0] p5_z_reg [4];
    logic [DW-1:0]        mag_dlat, mag_dlon, mag_lat1, mag_lat2;

    always_comb
    begin
        mag_dlat = (p2_dlat_reg < 0) ? DW'(-p2_dlat_reg) : DW'(p2_dlat_reg);
        mag_dlon = (p2_dlon_reg < 0) ? DW'(-p2_dlon_reg) : DW'(p2_dlon_reg);
        mag_lat1 = (p2_lat1_reg < 0) ? DW'(-p2_lat1_reg) : DW'(p2_lat1_reg);
        mag_lat2 = (p2_lat2_reg < 0) ? DW'(-p2_lat2_reg) : DW'(p2_lat2_reg);
        // half of a longitude gap beyond a half turn has the same squared sine
        if (mag_dlon > HALF_TURN)
            mag_dlon = FULL_TURN - mag_dlon;
        p3_m_next[0] = mag_dlat[AW-1:0];
        p3_m_next[1] = mag_dlon[AW-1:0];
        p3_m_next[2] = mag_lat1[AW-1:0];
        p3_m_next[3] = mag_lat2[AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_lat1_reg <= clamp_mag(DW'(points.first_latitude), LAT_LIM);
            p1_lon1_reg <= clamp_mag(DW'(points.first_longitude), LON_LIM);
            p1_lat2_reg <= clamp_mag(DW'(points.second_latitude), LAT_LIM);
            p1_lon2_reg <= clamp_mag(DW'(points.second_longitude), LON_LIM);

            p2_dlat_reg <= p1_lat2_reg - p1_lat1_reg;
            p2_dlon_reg <= p1_lon2_reg - p1_lon1_reg;
            p2_lat1_reg <= p1_lat1_reg;
            p2_lat2_reg <= p1_lat2_reg;

            for (int l = 0; l < 4; l++)
            begin
                p3_m_reg[l]    <= p3_m_next[l];
                p4_prod_reg[l] <= MW'(p3_m_reg[l]) * MW'(DEG2RAD_Q30);
            end

            // differences shift one bit further, so the halving shares a single rounding
            p5_z_reg[0] <= CW'((p4_prod_reg[0] + RND_HALF) >> (ANGLE_FRAC_BITS + 1));
            p5_z_reg[1] <= CW'((p4_prod_reg[1] + RND_HALF) >> (ANGLE_FRAC_BITS + 1));
            p5_z_reg[2] <= CW'((p4_prod_reg[2] + RND_FULL) >> ANGLE_FRAC_BITS);
            p5_z_reg[3] <= CW'((p4_prod_reg[3] + RND_FULL) >> ANGLE_FRAC_BITS);
        end
    end

    // rotation lanes: sin(dlat/2), sin(dlon/2), cos(lat1), cos(lat2)
    logic signed [CW-1:0] rx [4][N+1];
    logic signed [CW-1:0] ry [4][N+1];
    logic signed [CW-1:0] rz [4][N+1];

    for (genvar l = 0; l < 4; l++)
    begin : g_rot_lane
        assign rx[l][0] = INV_GAIN;
        assign ry[l][0] = '0;
        assign rz[l][0] = p5_z_reg[l];
        for (genvar s = 0; s < N; s++)
        begin : g_rot_step
            hav_rot_cell #(.STEP(s)) u_cell (
                .clk   (clk),
                .en    (adv),
                .x_in  (rx[l][s]),
                .y_in  (ry[l][s]),
                .z_in  (rz[l][s]),
                .x_reg (rx[l][s+1]),
                .y_reg (ry[l][s+1]),
                .z_reg (rz[l][s+1])
            );
        end
    end

    // haversine term
    logic [30:0]   s_dlat, s_dlon, c_lat1, c_lat2;
    logic [SW-1:0] prod_u2, prod_v2, prod_cc, prod_t;
    logic [30:0]   p6_u2_reg, p6_v2_reg, p6_cc_reg;
    logic [30:0]   p7_u2_reg, p7_t_reg;
    logic [31:0]   sum_a;
    logic [30:0]   a_sat;
    logic [SW-1:0] p8_va_reg, p8_vb_reg;

    always_comb
    begin
        s_dlat  = clamp_unit(ry[0][N]);
        s_dlon  = clamp_unit(ry[1][N]);
        c_lat1  = clamp_unit(rx[2][N]);
        c_lat2  = clamp_unit(rx[3][N]);
        prod_u2 = SW'(s_dlat) * SW'(s_dlat);
        prod_v2 = SW'(s_dlon) * SW'(s_dlon);
        prod_cc = SW'(c_lat1) * SW'(c_lat2);
        prod_t  = SW'(p6_cc_reg) * SW'(p6_v2_reg);
        sum_a   = 32'(p7_u2_reg) + 32'(p7_t_reg);
        a_sat   = (sum_a > 32'(Q30_ONE)) ? Q30_ONE : sum_a[30:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p6_u2_reg <= prod_u2[60:30];
            p6_v2_reg <= prod_v2[60:30];
            p6_cc_reg <= prod_cc[60:30];
            p7_u2_reg <= p6_u2_reg;
            p7_t_reg  <= prod_t[60:30];
            p8_va_reg <= SW'({a_sat, 30'b0});
            p8_vb_reg <= SW'({Q30_ONE - a_sat, 30'b0});
        end
    end

    // square roots of a and 1 - a
    logic [SW-1:0] sv [2][SQRT_STEPS+1];
    logic [SW-1:0] sr [2][SQRT_STEPS+1];

    assign sv[0][0] = p8_va_reg;
    assign sv[1][0] = p8_vb_reg;
    assign sr[0][0] = '0;
    assign sr[1][0] = '0;

    for (genvar l = 0; l < 2; l++)
    begin : g_sqrt_lane
        for (genvar k = 0; k < SQRT_STEPS; k++)
        begin : g_sqrt_step
            hav_sqrt_cell #(.POS(SQRT_STEPS - 1 - k)) u_cell (
                .clk   (clk),
                .en    (adv),
                .v_in  (sv[l][k]),
                .r_in  (sr[l][k]),
                .v_reg (sv[l][k+1]),
                .r_reg (sr[l][k+1])
            );
        end
    end

    // central angle = 2*atan2(sqrt(a), sqrt(1-a)); the factor two is in the diameter
    logic signed [CW-1:0] vx [N+1];
    logic signed [CW-1:0] vy [N+1];
    logic signed [CW-1:0] vz [N+1];

    assign vx[0] = CW'(sr[1][SQRT_STEPS][30:0]);
    assign vy[0] = CW'(sr[0][SQRT_STEPS][30:0]);
    assign vz[0] = '0;

    for (genvar s = 0; s < N; s++)
    begin : g_vec_step
        hav_vec_cell #(.STEP(s)) u_cell (
            .clk   (clk),
            .en    (adv),
            .x_in  (vx[s]),
            .y_in  (vy[s]),
            .z_in  (vz[s]),
            .x_reg (vx[s+1]),
            .y_reg (vy[s+1]),
            .z_reg (vz[s+1])
        );
    end

    // scale by the diameter, round, saturate
    logic [30:0]       ang;
    logic [PW-1:0]     p9_prod_reg;
    logic [PW:0]       rounded;
    logic [DIST_W-1:0] p10_dist_reg;

    always_comb
    begin
        ang     = (vz[N] < 0) ? '0 : vz[N][30:0];
        rounded = (PW+1)'(p9_prod_reg) + (PW+1)'(14'h2000);
        rounded = rounded >> 14;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p9_prod_reg  <= PW'(ang) * PW'(TWO_RADIUS_KM);
            p10_dist_reg <= (rounded > (PW+1)'(DIST_MAX)) ? DIST_MAX : rounded[DIST_W-1:0];
        end
    end

    assign result.distance_km = p10_dist_reg;

endmodule

@@ src/hav_checker.sv @@
// Port-level assertions for the haversine distance unit, bound to the top level.
module hav_checker
    import hav_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [DIST_W-1:0] distance_km
);

    // the row stalls only behind a waiting output item
    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not follow output stall");

    a_distance_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> distance_km <= DIST_MAX)
        else $error("distance above half circumference");

    a_output_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(distance_km))
        else $error("stalled output item changed");

    // an item accepted while the output waits would be lost
    a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !(in_valid && in_ready))
        else $error("item accepted during output stall");

endmodule

bind haversine_distance_unit hav_checker u_hav_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (points.valid),
    .in_ready    (points.ready),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .distance_km (result.distance_km)
);

@@ verif/tb_haversine_distance_unit.sv @@
// Testbench for haversine_distance_unit: random and corner point pairs vs. a fixed-point distance model.
`timescale 1ns / 1ps

module tb_haversine_distance_unit;
    import hav_pkg::*;

    localparam longint DEG      = 64'sd1 << 20;
    localparam longint LAT_LIM  = 90 * DEG;
    localparam longint LON_LIM  = 180 * DEG;
    localparam longint ONE_Q30  = 64'sd1 << 30;
    localparam int     STEPS    = 24;
    localparam int     CYCLE_LIMIT = 300000;

    typedef struct {
        logic signed [LAT_W-1:0] lat1;
        logic signed [LON_W-1:0] lon1;
        logic signed [LAT_W-1:0] lat2;
        logic signed [LON_W-1:0] lon2;
    } point_pair_t;

    logic clk;
    logic rst_n;

    hav_in_if  pts();
    hav_out_if res();

    haversine_distance_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .points (pts),
        .result (res)
    );

    point_pair_t          pair_q[$];
    logic [DIST_W-1:0]    dist_q[$];
    int                   errors;
    int                   cycle;

    longint arctan[32] = '{
        'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
        'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
        'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
        'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
        'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002,
        'h00000001, 'h00000000
    };

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic longint clip(longint v, longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    function automatic longint unit_clip(longint v);
        if (v < 0)
            return 0;
        if (v > ONE_Q30)
            return ONE_Q30;
        return v;
    endfunction

    function automatic longint deg_to_rad(longint mag, int shift);
        return (mag * 18740330 + (64'sd1 << (shift - 1))) >> shift;
    endfunction

    function automatic void rotate(input longint z, output longint c, output longint s);
        longint x;
        longint y;
        longint dx;
        longint dy;
        x = 652032874;
        y = 0;
        for (int i = 0; i < STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= arctan[i];
            end
            else
            begin
                x += dx; y -= dy; z += arctan[i];
            end
        end
        c = unit_clip(x);
        s = unit_clip(y);
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint z;
        longint dx;
        longint dy;
        z = 0;
        for (int i = 0; i < STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x += dx; y -= dy; z += arctan[i];
            end
            else
            begin
                x -= dx; y += dy; z -= arctan[i];
            end
        end
        return (z < 0) ? 0 : z;
    endfunction

    function automatic longint int_sqrt(longint v);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint half_sine_sq(longint diff);
        longint m;
        longint c;
        longint s;
        m = (diff < 0) ? -diff : diff;
        if (m > LON_LIM)
            m = 2 * LON_LIM - m;
        rotate(deg_to_rad(m, 21), c, s);
        return (s * s) >>> 30;
    endfunction

    function automatic longint lat_cosine(longint lat);
        longint c;
        longint s;
        rotate(deg_to_rad((lat < 0) ? -lat : lat, 20), c, s);
        return c;
    endfunction

    function automatic logic [DIST_W-1:0] great_circle(point_pair_t p);
        longint la1, lo1, la2, lo2, dlat, dlon, cc, a, sa, sb, ang, d;
        la1 = clip(longint'(p.lat1), LAT_LIM);
        lo1 = clip(longint'(p.lon1), LON_LIM);
        la2 = clip(longint'(p.lat2), LAT_LIM);
        lo2 = clip(longint'(p.lon2), LON_LIM);
        dlat = half_sine_sq(la2 - la1);
        dlon = half_sine_sq(lo2 - lo1);
        cc = (lat_cosine(la1) * lat_cosine(la2)) >>> 30;
        a = dlat + ((cc * dlon) >>> 30);
        if (a > ONE_Q30)
            a = ONE_Q30;
        sa = int_sqrt(a << 30);
        sb = int_sqrt((ONE_Q30 - a) << 30);
        ang = vector_angle(sa, sb);
        d = (ang * 12742 + 8192) >> 14;
        if (d > 1311769600)
            d = 1311769600;
        return d[DIST_W-1:0];
    endfunction

    function automatic point_pair_t mk(longint a, longint b, longint c, longint d);
        point_pair_t p;
        p.lat1 = a[LAT_W-1:0];
        p.lon1 = b[LON_W-1:0];
        p.lat2 = c[LAT_W-1:0];
        p.lon2 = d[LON_W-1:0];
        return p;
    endfunction

    function automatic longint rand_span(longint lim);
        return longint'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    // no idling during a calm stretch in the middle of the run
    function automatic bit take_break();
        if (cycle > 150 && cycle < 350)
            return 1'b0;
        return $urandom_range(0, 99) < 12;
    endfunction

    initial
    begin
        longint max_lat;
        longint max_lon;
        int     kind;
        max_lat = (64'sd1 << (LAT_W - 1)) - 1;
        max_lon = (64'sd1 << (LON_W - 1)) - 1;
        rst_n = 1'b0;
        pts.valid = 1'b0;
        pts.first_latitude = '0;
        pts.first_longitude = '0;
        pts.second_latitude = '0;
        pts.second_longitude = '0;
        res.ready = 1'b0;

        // directed corners
        pair_q = {pair_q, mk(0, 0, 0, 0)};
        pair_q = {pair_q, mk(LAT_LIM, 0, -LAT_LIM, 0)};
        pair_q = {pair_q, mk(0, -LON_LIM, 0, LON_LIM)};
        pair_q = {pair_q, mk(0, 0, 0, LON_LIM)};
        pair_q = {pair_q, mk(0, -90 * DEG, 0, 90 * DEG)};
        pair_q = {pair_q, mk(0, -170 * DEG, 0, 170 * DEG)};
        pair_q = {pair_q, mk(45 * DEG, 30 * DEG, -45 * DEG, -150 * DEG)};
        pair_q = {pair_q, mk(max_lat, max_lon, -max_lat - 1, -max_lon - 1)};
        pair_q = {pair_q, mk(-max_lat - 1, -max_lon - 1, max_lat, max_lon)};
        pair_q = {pair_q, mk(LAT_LIM + 1, LON_LIM + 1, -LAT_LIM - 1, -LON_LIM - 1)};
        pair_q = {pair_q, mk(LAT_LIM, 10 * DEG, LAT_LIM, 100 * DEG)};
        pair_q = {pair_q, mk(12 * DEG, 34 * DEG, 12 * DEG, 34 * DEG)};
        pair_q = {pair_q, mk(0, 0, 1, 1)};
        pair_q = {pair_q, mk(-1, -1, 0, 0)};
        pair_q = {pair_q, mk(51 * DEG, 0, 40 * DEG, -74 * DEG)};
        pair_q = {pair_q, mk(LAT_LIM - 1, LON_LIM - 1, -LAT_LIM + 1, -1)};
        pair_q = {pair_q, mk(30 * DEG, LON_LIM, -30 * DEG, 0)};
        pair_q = {pair_q, mk(0, 0, 0, 179 * DEG)};

        for (int n = 0; n < 400; n++)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 7)
                pair_q = {pair_q, mk(rand_span(LAT_LIM), rand_span(LON_LIM),
                                     rand_span(LAT_LIM), rand_span(LON_LIM))};
            else if (kind < 9)
                // close pairs
                pair_q = {pair_q, mk(rand_span(LAT_LIM), rand_span(LON_LIM),
                                     rand_span(LAT_LIM), rand_span(LON_LIM))};
            else
                pair_q = {pair_q, mk(longint'($urandom()), longint'($urandom()),
                                     longint'($urandom()), longint'($urandom()))};
            if (kind == 7 || kind == 8)
            begin
                pair_q[$].lat2 = pair_q[$].lat1 + LAT_W'($signed($urandom_range(0, 4096)) - 2048);
                pair_q[$].lon2 = pair_q[$].lon1 + LON_W'($signed($urandom_range(0, 4096)) - 2048);
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        wait (pair_q.size() == 0 && !pts.valid);
        wait (dist_q.size() == 0);
        repeat (120) @(posedge clk);
        if (errors == 0)
            $display("haversine_distance_unit regression: pass");
        else
            $display("haversine_distance_unit regression: fail");
        $finish;
    end

    // point pair driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pts.valid && pts.ready)
            begin
                point_pair_t cur;
                cur.lat1 = pts.first_latitude;
                cur.lon1 = pts.first_longitude;
                cur.lat2 = pts.second_latitude;
                cur.lon2 = pts.second_longitude;
                dist_q = {dist_q, great_circle(cur)};
            end
            if (!pts.valid || pts.ready)
            begin
                if (pair_q.size() > 0 && !take_break())
                begin
                    point_pair_t nxt;
                    nxt = pair_q.pop_front();
                    pts.first_latitude   <= nxt.lat1;
                    pts.first_longitude  <= nxt.lon1;
                    pts.second_latitude  <= nxt.lat2;
                    pts.second_longitude <= nxt.lon2;
                    pts.valid <= 1'b1;
                end
                else
                    pts.valid <= 1'b0;
            end
        end
    end

    // distance monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            res.ready <= !take_break();
            if (res.valid && res.ready)
            begin
                if (dist_q.size() == 0)
                begin
                    $display("%0t: distance %0d with none expected", $time, res.distance_km);
                    errors++;
                end
                else
                begin
                    logic [DIST_W-1:0] want;
                    want = dist_q.pop_front();
                    if (want !== res.distance_km)
                    begin
                        $display("%0t: distance_km expected %0d actual %0d",
                                 $time, want, res.distance_km);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > CYCLE_LIMIT)
        begin
            $display("haversine_distance_unit regression: fail");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        cycle = 0;
    end

endmodule
